// ===== rtl/dnkc_pkg.sv =====
package dnkc_pkg;

    // Width of a note index; holds key indices 0..7 plus the "no key" code KEY_COUNT.
    localparam int NOTE_W = 5;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd30;

    typedef enum logic [1:0] {
        NOTE_NONE = 2'd0,
        NOTE_ON   = 2'd1,
        NOTE_OFF  = 2'd2
    } t_note_ev;

    typedef enum logic [1:0] {
        REC_NONE  = 2'd0,
        REC_START = 2'd1,
        REC_STOP  = 2'd2
    } t_rec_ev;

    // One classified poll as it waits in the queue between front and back.
    typedef struct packed {
        logic [31:0]       now;
        logic [NOTE_W-1:0] note;
        logic              rkey;
        logic              link;
        logic [15:0]       freq;
    } t_item;

    typedef struct packed {
        logic        tone_active;
        logic [15:0] tone_freq;
        t_note_ev    note_event;
        t_rec_ev     record_event;
        logic        rec_active;
        logic        link_led;
        logic        warn;
        logic [31:0] event_time;
    } t_result;

    // 2^(a/12) in unsigned Q16.
    function automatic logic [16:0] pow12(input logic [3:0] a);
        logic [16:0] v;
        case (a)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd69433;
            4'd2:    v = 17'd73562;
            4'd3:    v = 17'd77936;
            4'd4:    v = 17'd82570;
            4'd5:    v = 17'd87480;
            4'd6:    v = 17'd92682;
            4'd7:    v = 17'd98193;
            4'd8:    v = 17'd104032;
            4'd9:    v = 17'd110218;
            4'd10:   v = 17'd116772;
            4'd11:   v = 17'd123715;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // 2^(b/120) in unsigned Q16.
    function automatic logic [16:0] pow120(input logic [3:0] b);
        logic [16:0] v;
        case (b)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65916;
            4'd2:    v = 17'd66297;
            4'd3:    v = 17'd66682;
            4'd4:    v = 17'd67068;
            4'd5:    v = 17'd67456;
            4'd6:    v = 17'd67847;
            4'd7:    v = 17'd68240;
            4'd8:    v = 17'd68635;
            4'd9:    v = 17'd69033;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // Base frequency in hertz of each note key.
    function automatic logic [9:0] base_freq(input logic [2:0] key);
        logic [9:0] v;
        case (key)
            3'd0:    v = 10'd262;
            3'd1:    v = 10'd294;
            3'd2:    v = 10'd330;
            3'd3:    v = 10'd349;
            3'd4:    v = 10'd392;
            3'd5:    v = 10'd440;
            3'd6:    v = 10'd494;
            3'd7:    v = 10'd523;
            default: v = 10'd262;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/dnkc_front.sv =====
module dnkc_front
    import dnkc_pkg::*;
#(
    parameter int KEY_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [31:0]       i_poll_time_ms,
    input  logic [7:0]        i_note_keys,
    input  logic              i_record_key,
    input  logic              i_link_status,
    input  logic signed [7:0] i_pitch_tenths,
    input  logic              i_q_full,
    output logic              o_push,
    output t_item             o_item
);

    typedef struct packed {
        logic [31:0]       now;
        logic [NOTE_W-1:0] note;
        logic [2:0]        key;
        logic              rkey;
        logic              link;
    } t_ctl;

    typedef struct packed {
        t_ctl       ctl;
        logic [1:0] oct;
        logic [3:0] semi;
        logic [3:0] tenth;
    } t_s1;

    typedef struct packed {
        t_ctl        ctl;
        logic [1:0]  oct;
        logic [33:0] mult;
    } t_s2;

    logic  r_s1_v, r_s2_v, r_s3_v;
    t_s1   r_s1, n_s1;
    t_s2   r_s2, n_s2;
    t_item r_s3, n_s3;
    logic  s1_ready, s2_ready, s3_ready;

    logic [8:0]  t_off;
    logic [6:0]  rem;
    logic [43:0] prod;
    logic [43:0] shifted;

    assign s3_ready   = !r_s3_v || !i_q_full;
    assign s2_ready   = !r_s2_v || s3_ready;
    assign s1_ready   = !r_s1_v || s2_ready;
    assign o_in_stall = !s1_ready;
    assign o_push     = r_s3_v && !i_q_full;
    assign o_item     = r_s3;

    // Stage 1: pick the lowest pressed key and split the pitch into octave,
    // semitone and tenth steps.
    always_comb begin
        n_s1          = '0;
        n_s1.ctl.now  = i_poll_time_ms;
        n_s1.ctl.rkey = i_record_key;
        n_s1.ctl.link = i_link_status;
        n_s1.ctl.note = NOTE_W'(KEY_COUNT);
        n_s1.ctl.key  = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (i < KEY_COUNT && !i_note_keys[i]) begin
                n_s1.ctl.note = NOTE_W'(i);
                n_s1.ctl.key  = 3'(i);
            end
        end

        t_off = 9'(10'($signed(i_pitch_tenths)) + 10'd240);
        if (t_off >= 9'd360) begin
            n_s1.oct = 2'd3;
            rem      = 7'(t_off - 9'd360);
        end else if (t_off >= 9'd240) begin
            n_s1.oct = 2'd2;
            rem      = 7'(t_off - 9'd240);
        end else if (t_off >= 9'd120) begin
            n_s1.oct = 2'd1;
            rem      = 7'(t_off - 9'd120);
        end else begin
            n_s1.oct = 2'd0;
            rem      = 7'(t_off);
        end

        n_s1.semi  = 4'd0;
        n_s1.tenth = 4'(rem);
        for (int k = 1; k < 12; k++) begin
            if (rem >= 7'(10 * k)) begin
                n_s1.semi  = 4'(k);
                n_s1.tenth = 4'(rem - 7'(10 * k));
            end
        end
    end

    // Stage 2: combined pitch ratio in Q32.
    always_comb begin
        n_s2      = '0;
        n_s2.ctl  = r_s1.ctl;
        n_s2.oct  = r_s1.oct;
        n_s2.mult = 34'(pow12(r_s1.semi)) * 34'(pow120(r_s1.tenth));
    end

    // Stage 3: scale the base frequency, drop the fraction and saturate.
    always_comb begin
        prod      = 44'(base_freq(r_s2.ctl.key)) * 44'(r_s2.mult);
        shifted   = prod >> (6'd34 - {4'd0, r_s2.oct});
        n_s3      = '0;
        n_s3.now  = r_s2.ctl.now;
        n_s3.note = r_s2.ctl.note;
        n_s3.rkey = r_s2.ctl.rkey;
        n_s3.link = r_s2.ctl.link;
        n_s3.freq = (|shifted[43:16]) ? 16'hFFFF : shifted[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_v <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_v <= r_s1_v;
            end
            if (s3_ready) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1 <= n_s1;
        end
        if (s2_ready) begin
            r_s2 <= n_s2;
        end
        if (s3_ready) begin
            r_s3 <= n_s3;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_v && r_s2_v && r_s3_v && i_q_full))
        else $error("front stalls with room in its pipeline");

    a_s3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_v && i_q_full) |=> (r_s3_v && $stable(r_s3)))
        else $error("blocked stage 3 item changed");

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && !s3_ready) |=> (r_s2_v && $stable(r_s2)))
        else $error("blocked stage 2 item changed");

endmodule

// ===== rtl/dnkc_fifo.sv =====
module dnkc_fifo
    import dnkc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

// ===== rtl/dnkc_back.sv =====
module dnkc_back
    import dnkc_pkg::*;
#(
    parameter int KEY_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_debounce_ms,
    input  t_item       i_item,
    input  logic        i_q_empty,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_result
);

    localparam logic [NOTE_W-1:0] KEY_NONE = NOTE_W'(KEY_COUNT);

    logic [NOTE_W-1:0] r_cand_note, n_cand_note;
    logic [31:0]       r_cand_since, n_cand_since;
    logic [NOTE_W-1:0] r_playing, n_playing;
    logic              r_recording, n_recording;
    logic              r_last_rkey;
    logic [15:0]       r_last_freq, n_last_freq;
    logic              r_out_valid;
    t_result           r_out, n_out;

    logic [31:0] elapsed;
    logic        fire;
    logic        press;
    logic        warn;
    t_note_ev    note_ev;
    t_rec_ev     rec_ev;

    assign o_pop       = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_recording = r_recording;
        warn        = 1'b0;
        note_ev     = NOTE_NONE;
        rec_ev      = REC_NONE;

        // Link loss drops recording first.
        if (!i_item.link && r_recording) begin
            n_recording = 1'b0;
            warn        = 1'b1;
        end

        n_cand_note  = i_item.note;
        n_cand_since = (i_item.note != r_cand_note) ? i_item.now : r_cand_since;
        elapsed      = i_item.now - n_cand_since;
        fire         = (elapsed > {16'd0, i_debounce_ms}) && (i_item.note != r_playing);

        n_playing   = r_playing;
        n_last_freq = r_last_freq;
        if (fire) begin
            n_playing = i_item.note;
            if (i_item.note >= KEY_NONE) begin
                n_last_freq = 16'd0;
                if (n_recording) begin
                    note_ev = NOTE_OFF;
                end
            end else begin
                n_last_freq = i_item.freq;
                if (n_recording) begin
                    note_ev = NOTE_ON;
                end
            end
        end

        press = !i_item.rkey && r_last_rkey;
        if (press) begin
            if (!n_recording) begin
                if (!i_item.link) begin
                    warn = 1'b1;
                end else begin
                    n_recording = 1'b1;
                    rec_ev      = REC_START;
                end
            end else begin
                n_recording = 1'b0;
                rec_ev      = REC_STOP;
            end
        end

        n_out.tone_active  = (n_playing < KEY_NONE);
        n_out.tone_freq    = (n_playing < KEY_NONE) ? n_last_freq : 16'd0;
        n_out.note_event   = note_ev;
        n_out.record_event = rec_ev;
        n_out.rec_active   = n_recording;
        n_out.link_led     = i_item.link;
        n_out.warn         = warn;
        n_out.event_time   = (note_ev != NOTE_NONE || rec_ev != REC_NONE) ? i_item.now : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_note  <= KEY_NONE;
            r_cand_since <= 32'd0;
            r_playing    <= KEY_NONE;
            r_recording  <= 1'b0;
            r_last_rkey  <= 1'b1;
            r_last_freq  <= 16'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cand_note  <= n_cand_note;
                r_cand_since <= n_cand_since;
                r_playing    <= n_playing;
                r_recording  <= n_recording;
                r_last_rkey  <= i_item.rkey;
                r_last_freq  <= n_last_freq;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_start_sets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.record_event == REC_START) |-> r_out.rec_active)
        else $error("recording start reported with recording off");

    a_stop_clears_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.record_event == REC_STOP) |-> !r_out.rec_active)
        else $error("recording stop reported with recording on");

    a_silent_zero_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.tone_active) |-> (r_out.tone_freq == 16'd0))
        else $error("silent tone with nonzero frequency");

    a_pop_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped item did not reach the output register");

endmodule

// ===== rtl/debounced_note_key_controller.sv =====
// Channel   Direction  Handshake                 Moves
// --------  ---------  ------------------------  ---------------------------------------
// cfg       in         i_cfg_valid/o_cfg_ready   debounce time in milliseconds
// in        in         i_in_valid/o_in_stall     one poll: time, keys, record, link, pitch
// out       out        o_out_valid/i_out_stall   one result per poll
//
// One poll can be taken every cycle while o_in_stall is low. A poll's result passes
// three front stage registers, the first loaded by the transfer itself, then one
// queue entry, then the output register. The front multiplier chain sets the depth.
// Reset is synchronous and active low; it returns debounce_ms to 30 and all key and
// recording state to idle. A stalled output holds its result; the queue absorbs the
// front's work, and only when it and the front stages are all full is o_in_stall raised.
module debounced_note_key_controller
    import dnkc_pkg::*;
#(
    parameter int KEY_COUNT   = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_debounce_ms,

    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [31:0]       i_poll_time_ms,
    input  logic [7:0]        i_note_keys,
    input  logic              i_record_key,
    input  logic              i_link_status,
    input  logic signed [7:0] i_pitch_tenths,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_tone_active,
    output logic [15:0]       o_tone_freq,
    output logic [1:0]        o_note_event,
    output logic [1:0]        o_record_event,
    output logic              o_rec_active,
    output logic              o_link_led,
    output logic              o_warn_pulse,
    output logic [31:0]       o_event_time
);

    // The debounce register is always ready; a transfer overwrites it.
    logic [15:0] r_debounce_ms;

    logic    push, pop, q_full, q_empty;
    t_item   front_item, q_item;
    t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_debounce_ms <= i_cfg_debounce_ms;
        end
    end

    // The front scans the keys and works out the pitch-shifted frequency of the
    // lowest pressed key. None of that depends on the block's state, so it runs
    // freely ahead of the back.
    dnkc_front #(
        .KEY_COUNT (KEY_COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_poll_time_ms (i_poll_time_ms),
        .i_note_keys    (i_note_keys),
        .i_record_key   (i_record_key),
        .i_link_status  (i_link_status),
        .i_pitch_tenths (i_pitch_tenths),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_item         (front_item)
    );

    dnkc_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (q_item),
        .o_empty (q_empty)
    );

    // The back holds all state: debounce, playing note, recording mode and the
    // record key edge detector. Unless the output stalls, it finishes one poll per cycle
    // into the output register, so it can pop a new poll as the last result is taken.
    dnkc_back #(
        .KEY_COUNT (KEY_COUNT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_debounce_ms (r_debounce_ms),
        .i_item        (q_item),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result      (result)
    );

    assign o_tone_active  = result.tone_active;
    assign o_tone_freq    = result.tone_freq;
    assign o_note_event   = result.note_event;
    assign o_record_event = result.record_event;
    assign o_rec_active   = result.rec_active;
    assign o_link_led     = result.link_led;
    assign o_warn_pulse   = result.warn;
    assign o_event_time   = result.event_time;

endmodule
